@@ rtl/arm_shifter_operand_top_defines.svh @@
// Assertion macros for the ARM shifter operand block.
// Used by the port checker; depends on nothing else.
`ifndef ARM_SHIFTER_OPERAND_TOP_DEFINES_SVH
`define ARM_SHIFTER_OPERAND_TOP_DEFINES_SVH

// Check that cons holds whenever ante holds, outside reset.
`define ASOP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that expr holds at every edge outside reset.
`define ASOP_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   `ASOP_ASSERT_IMPL(label, clk, rst, 1'b1, expr, msg)

`endif

@@ rtl/asop_pkg.sv @@
// Shared types, codes and helpers for the ARM shifter operand pipeline.
// Used by every module of the block; depends on nothing.
package asop_pkg;

   localparam int unsigned DataWidth = 32;
   localparam int unsigned RotWidth  = 5;
   localparam int unsigned CntWidth  = 6;

   localparam logic [1:0] ACT_ROT_IMM = 2'd0;
   localparam logic [1:0] ACT_IMM_SH  = 2'd1;
   localparam logic [1:0] ACT_REG_SH  = 2'd2;

   localparam logic [1:0] SH_LSL = 2'd0;
   localparam logic [1:0] SH_LSR = 2'd1;
   localparam logic [1:0] SH_ASR = 2'd2;
   localparam logic [1:0] SH_ROR = 2'd3;

   localparam logic [7:0] REG_AMT_FULL = 8'd32;
   localparam logic [CntWidth-1:0] CNT_FULL = 6'd32;

   typedef struct packed {
      logic [1:0]           action;
      logic [1:0]           shift_type;
      logic [7:0]           amount;
      logic [DataWidth-1:0] value;
      logic                 carry_flag;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] operand;
      logic                 carry_out;
   } rsp_type;

   // Shift reduced to: rotate right, then replace masked-out bits by fill.
   typedef struct packed {
      logic [DataWidth-1:0] value;
      logic [RotWidth-1:0]  rot;
      logic                 left;
      logic [CntWidth-1:0]  cnt;
      logic                 fill;
      logic                 carry_from_bit;
      logic [RotWidth-1:0]  carry_bit;
      logic                 carry_const;
   } dec_type;

   typedef struct packed {
      logic [DataWidth-1:0] rotated;
      logic [DataWidth-1:0] keep;
      logic                 fill;
      logic                 carry;
   } rot_type;

   function automatic logic [DataWidth-1:0] rotr(input logic [DataWidth-1:0] v,
                                                 input logic [RotWidth-1:0] n);
      logic [2*DataWidth-1:0] both;
      both = {v, v} >> n;
      return both[DataWidth-1:0];
   endfunction

endpackage

@@ rtl/arm_shifter_operand_top.sv @@
// Top level of the ARM data-processing shifter operand unit.
// Depends on asop_pkg, asop_decode, asop_rotate and asop_merge.
//
// Usage:
//   A request (req_data) is taken at a rising edge with start high and busy
//   low. busy is high only while reset is high; otherwise every cycle can
//   take a new request.
//   Each request gives one response on rsp_data, marked by rsp_valid for
//   exactly one cycle. The receiver cannot hold responses off.
//   Pipeline: three register stages (decode, rotate, merge); a request is
//   registered in each in turn before its response is strobed.
//   Throughput: one request per cycle, set by the single rotator and mask
//   stage that each request passes once.
//   Reset clears the stage valid bits; requests in flight are dropped and
//   no response is strobed for them.
module arm_shifter_operand_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  asop_pkg::req_type req_data,
   output logic              rsp_valid,
   output asop_pkg::rsp_type rsp_data
);

   logic              dec_valid;
   asop_pkg::dec_type dec_data;
   logic              rot_valid;
   asop_pkg::rot_type rot_data;
   logic              accept;

   assign busy   = reset;
   assign accept = start && !busy;

   asop_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_data),
      .out_valid (dec_valid),
      .out_dec   (dec_data)
   );

   asop_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_dec    (dec_data),
      .out_valid (rot_valid),
      .out_rot   (rot_data)
   );

   asop_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_rot    (rot_data),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule

@@ rtl/asop_decode.sv @@
// Stage one: decode the request into rotate amount, mask, fill and carry source.
// Depends on asop_pkg.
module asop_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  asop_pkg::req_type in_req,
   output logic              out_valid,
   output asop_pkg::dec_type out_dec
);

   logic              valid_ff;
   asop_pkg::dec_type dec_ff;
   asop_pkg::dec_type dec_in;

   logic [asop_pkg::RotWidth-1:0] n5;
   logic [asop_pkg::RotWidth-1:0] neg5;
   logic [asop_pkg::RotWidth-1:0] nm1;
   logic                          big;
   logic                          eq32;
   logic                          sign;

   always_comb begin
      n5   = in_req.amount[asop_pkg::RotWidth-1:0];
      neg5 = asop_pkg::RotWidth'(0) - n5;
      nm1  = n5 - asop_pkg::RotWidth'(1);
      big  = |in_req.amount[7:5];
      eq32 = (in_req.amount == asop_pkg::REG_AMT_FULL);
      sign = in_req.value[31];

      dec_in.value          = in_req.value;
      dec_in.rot            = '0;
      dec_in.left           = 1'b0;
      dec_in.cnt            = '0;
      dec_in.fill           = 1'b0;
      dec_in.carry_from_bit = 1'b0;
      dec_in.carry_bit      = '0;
      dec_in.carry_const    = in_req.carry_flag;

      unique case (in_req.action)
         asop_pkg::ACT_ROT_IMM: begin
            dec_in.value = {24'd0, in_req.value[7:0]};
            dec_in.rot   = {in_req.amount[3:0], 1'b0};
            if (in_req.amount[3:0] != 4'd0) begin
               dec_in.carry_from_bit = 1'b1;
               dec_in.carry_bit      = {in_req.amount[3:0], 1'b0} - asop_pkg::RotWidth'(1);
            end
         end
         asop_pkg::ACT_IMM_SH: begin
            dec_in.carry_from_bit = 1'b1;
            unique case (in_req.shift_type)
               asop_pkg::SH_LSL: begin
                  if (n5 == '0) begin
                     dec_in.carry_from_bit = 1'b0;
                  end else begin
                     dec_in.rot       = neg5;
                     dec_in.left      = 1'b1;
                     dec_in.cnt       = {1'b0, n5};
                     dec_in.carry_bit = neg5;
                  end
               end
               asop_pkg::SH_LSR, asop_pkg::SH_ASR: begin
                  dec_in.fill = (in_req.shift_type == asop_pkg::SH_ASR) && sign;
                  if (n5 == '0) begin
                     dec_in.cnt       = asop_pkg::CNT_FULL;
                     dec_in.carry_bit = 5'd31;
                  end else begin
                     dec_in.rot       = n5;
                     dec_in.cnt       = {1'b0, n5};
                     dec_in.carry_bit = nm1;
                  end
               end
               asop_pkg::SH_ROR: begin
                  if (n5 == '0) begin
                     dec_in.rot       = 5'd1;
                     dec_in.cnt       = 6'd1;
                     dec_in.fill      = in_req.carry_flag;
                     dec_in.carry_bit = '0;
                  end else begin
                     dec_in.rot       = n5;
                     dec_in.carry_bit = nm1;
                  end
               end
               default: ;
            endcase
         end
         asop_pkg::ACT_REG_SH: begin
            if (in_req.amount != 8'd0) begin
               dec_in.carry_from_bit = 1'b1;
               unique case (in_req.shift_type)
                  asop_pkg::SH_LSL: begin
                     dec_in.left = 1'b1;
                     if (big) begin
                        dec_in.cnt       = asop_pkg::CNT_FULL;
                        dec_in.carry_bit = '0;
                        if (!eq32) begin
                           dec_in.carry_from_bit = 1'b0;
                           dec_in.carry_const    = 1'b0;
                        end
                     end else begin
                        dec_in.rot       = neg5;
                        dec_in.cnt       = {1'b0, n5};
                        dec_in.carry_bit = neg5;
                     end
                  end
                  asop_pkg::SH_LSR, asop_pkg::SH_ASR: begin
                     dec_in.fill = (in_req.shift_type == asop_pkg::SH_ASR) && sign;
                     if (big) begin
                        dec_in.cnt       = asop_pkg::CNT_FULL;
                        dec_in.carry_bit = 5'd31;
                        if (!eq32 && in_req.shift_type == asop_pkg::SH_LSR) begin
                           dec_in.carry_from_bit = 1'b0;
                           dec_in.carry_const    = 1'b0;
                        end
                     end else begin
                        dec_in.rot       = n5;
                        dec_in.cnt       = {1'b0, n5};
                        dec_in.carry_bit = nm1;
                     end
                  end
                  asop_pkg::SH_ROR: begin
                     dec_in.rot       = n5;
                     dec_in.carry_bit = nm1;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      dec_ff <= dec_in;
   end

   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;

endmodule

@@ rtl/asop_rotate.sv @@
// Stage two: rotate the value, build the keep mask and pick the carry.
// Depends on asop_pkg.
module asop_rotate (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  asop_pkg::dec_type in_dec,
   output logic              out_valid,
   output asop_pkg::rot_type out_rot
);

   logic              valid_ff;
   asop_pkg::rot_type rot_ff;
   asop_pkg::rot_type rot_in;

   logic [asop_pkg::DataWidth-1:0] ones;

   always_comb begin
      ones           = '1;
      rot_in.rotated = asop_pkg::rotr(in_dec.value, in_dec.rot);
      rot_in.keep    = in_dec.left ? (ones << in_dec.cnt) : (ones >> in_dec.cnt);
      rot_in.fill    = in_dec.fill;
      rot_in.carry   = in_dec.carry_from_bit ? in_dec.value[in_dec.carry_bit]
                                             : in_dec.carry_const;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rot_ff <= rot_in;
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;

endmodule

@@ rtl/asop_merge.sv @@
// Stage three: merge rotated bits with fill and register the response.
// Depends on asop_pkg.
module asop_merge (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  asop_pkg::rot_type in_rot,
   output logic              out_valid,
   output asop_pkg::rsp_type out_rsp
);

   logic              valid_ff;
   asop_pkg::rsp_type rsp_ff;
   asop_pkg::rsp_type rsp_in;

   always_comb begin
      rsp_in.operand   = (in_rot.rotated & in_rot.keep)
                       | ({asop_pkg::DataWidth{in_rot.fill}} & ~in_rot.keep);
      rsp_in.carry_out = in_rot.carry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

@@ rtl/asop_checker.sv @@
// Port-level checker for arm_shifter_operand_top, bound to the top level.
// Depends on asop_pkg and arm_shifter_operand_top_defines.svh.
`include "arm_shifter_operand_top_defines.svh"

module asop_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input asop_pkg::req_type req_data,
   input logic              rsp_valid,
   input asop_pkg::rsp_type rsp_data
);

   logic              accept;
   logic              lsl0;
   logic              lsr_big;
   asop_pkg::rsp_type pass_rsp;

   assign accept   = start && !busy;
   assign lsl0     = accept && req_data.action == asop_pkg::ACT_IMM_SH
                     && req_data.shift_type == asop_pkg::SH_LSL
                     && req_data.amount[4:0] == 5'd0;
   assign lsr_big  = accept && req_data.action == asop_pkg::ACT_REG_SH
                     && req_data.shift_type == asop_pkg::SH_LSR
                     && req_data.amount > asop_pkg::REG_AMT_FULL;
   assign pass_rsp = {req_data.value, req_data.carry_flag};

   `ASOP_ASSERT_ALWAYS(a_busy_only_in_reset, clock, reset, !busy, "busy outside reset")

   `ASOP_ASSERT_ALWAYS(a_latency, clock, reset, rsp_valid == $past(accept, 3), "strobe timing")

   `ASOP_ASSERT_IMPL(a_lsl0, clock, reset, $past(lsl0, 3), rsp_data == $past(pass_rsp, 3), "LSL #0")

   `ASOP_ASSERT_IMPL(a_lsr_big, clock, reset, $past(lsr_big, 3), rsp_data == '0, "LSR above 32")

endmodule

bind arm_shifter_operand_top asop_checker u_checker (.*);

@@ test/tb_arm_shifter_operand_top.sv @@
`timescale 1ns / 100ps
// Testbench for arm_shifter_operand_top: directed vector table, then random requests.
// Predicts operand and carry for CALC requests. Depends on asop_pkg and the RTL.
module tb_arm_shifter_operand_top;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam bit FIXED = 1'b1;
   localparam bit CALC = 1'b0;
   localparam int unsigned RANDOM_ITEMS = 830;
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned MAX_REPORTS = 10;

   typedef struct packed {
      asop_pkg::req_type req;
      logic              fixed;
      asop_pkg::rsp_type want;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic rsp_valid;
   asop_pkg::req_type req_data = '0;
   asop_pkg::rsp_type rsp_data;

   logic want_fixed = 1'b0;
   asop_pkg::rsp_type want_rsp = '0;

   asop_pkg::rsp_type due_q[$];
   int unsigned mismatches = 0;
   int unsigned reports = 0;
   int unsigned idle_cycles = 0;
   int unsigned n_checked = 0;
   int unsigned n_fixed = 0;
   int unsigned act_seen [4] = '{0, 0, 0, 0};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   arm_shifter_operand_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
      return (v >> n) | (v << (6'd32 - {1'b0, n}));
   endfunction

   function automatic asop_pkg::rsp_type shift_operand(input asop_pkg::req_type r);
      logic [31:0]       v;
      logic [31:0]       op;
      logic              co;
      logic [7:0]        n;
      logic [4:0]        n5;
      logic [4:0]        cb;
      logic [3:0]        rot;
      int                k;
      asop_pkg::rsp_type res;
      v = r.value;
      op = v;
      co = r.carry_flag;
      n = r.amount;
      n5 = r.amount[4:0];
      cb = n5 - 5'd1;
      k = 32 - int'(n);
      unique case (r.action)
         asop_pkg::ACT_ROT_IMM: begin
            rot = r.amount[3:0];
            op = ror32({24'd0, v[7:0]}, {rot, 1'b0});
            if (rot != 4'd0) co = op[31];
         end
         asop_pkg::ACT_IMM_SH: begin
            k = 32 - int'(n5);
            unique case (r.shift_type)
               asop_pkg::SH_LSL: if (n5 != 5'd0) begin
                  op = v << n5;
                  co = v[k];
               end
               asop_pkg::SH_LSR: if (n5 == 5'd0) begin
                  op = '0;
                  co = v[31];
               end else begin
                  op = v >> n5;
                  co = v[cb];
               end
               asop_pkg::SH_ASR: if (n5 == 5'd0) begin
                  op = {32{v[31]}};
                  co = v[31];
               end else begin
                  op = $signed(v) >>> n5;
                  co = v[cb];
               end
               asop_pkg::SH_ROR: if (n5 == 5'd0) begin
                  op = {r.carry_flag, v[31:1]};
                  co = v[0];
               end else begin
                  op = ror32(v, n5);
                  co = v[cb];
               end
            endcase
         end
         asop_pkg::ACT_REG_SH: if (n != 8'd0) begin
            unique case (r.shift_type)
               asop_pkg::SH_LSL: if (n < asop_pkg::REG_AMT_FULL) begin
                  op = v << n;
                  co = v[k];
               end else if (n == asop_pkg::REG_AMT_FULL) begin
                  op = '0;
                  co = v[0];
               end else begin
                  op = '0;
                  co = 1'b0;
               end
               asop_pkg::SH_LSR: if (n < asop_pkg::REG_AMT_FULL) begin
                  op = v >> n;
                  co = v[cb];
               end else if (n == asop_pkg::REG_AMT_FULL) begin
                  op = '0;
                  co = v[31];
               end else begin
                  op = '0;
                  co = 1'b0;
               end
               asop_pkg::SH_ASR: if (n < asop_pkg::REG_AMT_FULL) begin
                  op = $signed(v) >>> n;
                  co = v[cb];
               end else begin
                  op = {32{v[31]}};
                  co = v[31];
               end
               asop_pkg::SH_ROR: begin
                  op = ror32(v, n5);
                  co = v[cb];
               end
            endcase
         end
         default: ;
      endcase
      res.operand = op;
      res.carry_out = co;
      return res;
   endfunction

   function automatic vector_type vec(input logic [1:0] act, input logic [1:0] st,
                                      input logic [7:0] amt, input logic [31:0] val,
                                      input logic cin, input logic fixed,
                                      input logic [31:0] op, input logic co);
      vector_type t;
      t.req.action = act;
      t.req.shift_type = st;
      t.req.amount = amt;
      t.req.value = val;
      t.req.carry_flag = cin;
      t.fixed = fixed;
      t.want.operand = op;
      t.want.carry_out = co;
      return t;
   endfunction

   function automatic asop_pkg::req_type rand_request();
      asop_pkg::req_type r;
      int unsigned       pick;
      pick = $urandom_range(0, 99);
      r.action = pick < 30 ? asop_pkg::ACT_ROT_IMM : pick < 60 ? asop_pkg::ACT_IMM_SH :
                 pick < 95 ? asop_pkg::ACT_REG_SH : ACT_UNUSED;
      r.shift_type = 2'($urandom_range(0, 3));
      r.amount = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (r.action == asop_pkg::ACT_REG_SH) begin
         if (pick < 50) r.amount = 8'($urandom_range(0, 40));
         else if (pick < 70) begin
            r.amount = asop_pkg::REG_AMT_FULL + 8'($urandom_range(0, 2)) - 8'd1;
         end
      end else if (r.action == asop_pkg::ACT_IMM_SH && pick < 20) begin
         r.amount[4:0] = 5'd0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) r.value = '1;
      else if (pick < 20) r.value = '0;
      else if (pick < 30) r.value = 32'd1 << $urandom_range(0, 31);
      else r.value = $urandom;
      r.carry_flag = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic issue(input asop_pkg::req_type r, input logic fixed,
                        input asop_pkg::rsp_type want, input int unsigned gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      want_fixed <= fixed;
      want_rsp <= want;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (due_q.size() != 0);
   endtask

   // Record accepted requests and check strobed responses.
   always @(posedge clock) begin
      asop_pkg::rsp_type due;
      if (!reset && start && busy === 1'b0) begin
         due_q.push_back(want_fixed ? want_rsp : shift_operand(req_data));
         act_seen[req_data.action]++;
         if (want_fixed) n_fixed++;
      end
      if (rsp_valid === 1'b1) begin
         n_checked++;
         if (due_q.size() == 0) begin
            mismatches++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("[%0t] unexpected response: operand=%h carry=%b",
                        $realtime, rsp_data.operand, rsp_data.carry_out);
            end
         end else begin
            due = due_q.pop_front();
            if (rsp_data.operand !== due.operand || rsp_data.carry_out !== due.carry_out) begin
               mismatches++;
               if (reports < MAX_REPORTS) begin
                  reports++;
                  $display("[%0t] mismatch: operand exp=%h got=%h, carry exp=%b got=%b",
                           $realtime, due.operand, rsp_data.operand,
                           due.carry_out, rsp_data.carry_out);
               end
            end
         end
      end
   end

   // Abort when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", due_q.size());
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      vector_type  vectors[$];
      int unsigned i;
      int unsigned gap;
      vectors.push_back(vec(asop_pkg::ACT_ROT_IMM, asop_pkg::SH_ASR, 8'h00, 32'hFFFF_FFFF,
                            1'b1, FIXED, 32'h0000_00FF, 1'b1));
      vectors.push_back(vec(asop_pkg::ACT_ROT_IMM, asop_pkg::SH_LSL, 8'h01, 32'h0000_00FF,
                            1'b0, CALC, '0, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_ROT_IMM, asop_pkg::SH_ROR, 8'hFF, 32'hFFFF_FF81,
                            1'b1, CALC, '0, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_IMM_SH, asop_pkg::SH_LSL, 8'h00, 32'h8000_0001,
                            1'b0, FIXED, 32'h8000_0001, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_IMM_SH, asop_pkg::SH_LSR, 8'hE0, 32'h8000_0000,
                            1'b0, FIXED, 32'h0000_0000, 1'b1));
      vectors.push_back(vec(asop_pkg::ACT_IMM_SH, asop_pkg::SH_ASR, 8'h00, 32'h8000_0000,
                            1'b0, FIXED, 32'hFFFF_FFFF, 1'b1));
      vectors.push_back(vec(asop_pkg::ACT_IMM_SH, asop_pkg::SH_ASR, 8'h00, 32'h7FFF_FFFF,
                            1'b1, FIXED, 32'h0000_0000, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_IMM_SH, asop_pkg::SH_ROR, 8'h00, 32'h0000_0001,
                            1'b1, FIXED, 32'h8000_0000, 1'b1));
      vectors.push_back(vec(asop_pkg::ACT_IMM_SH, asop_pkg::SH_LSL, 8'hFF, 32'hFFFF_FFFF,
                            1'b0, CALC, '0, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_IMM_SH, asop_pkg::SH_LSR, 8'h01, 32'h8000_0001,
                            1'b0, CALC, '0, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_IMM_SH, asop_pkg::SH_ASR, 8'h1F, 32'h8000_0000,
                            1'b1, CALC, '0, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_IMM_SH, asop_pkg::SH_ROR, 8'h3F, 32'h1234_5678,
                            1'b0, CALC, '0, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_REG_SH, asop_pkg::SH_LSL, 8'h00, 32'hDEAD_BEEF,
                            1'b1, FIXED, 32'hDEAD_BEEF, 1'b1));
      vectors.push_back(vec(asop_pkg::ACT_REG_SH, asop_pkg::SH_LSL, 8'd32, 32'h0000_0001,
                            1'b0, FIXED, 32'h0000_0000, 1'b1));
      vectors.push_back(vec(asop_pkg::ACT_REG_SH, asop_pkg::SH_LSR, 8'd32, 32'h8000_0000,
                            1'b0, FIXED, 32'h0000_0000, 1'b1));
      vectors.push_back(vec(asop_pkg::ACT_REG_SH, asop_pkg::SH_LSL, 8'd33, 32'hFFFF_FFFF,
                            1'b1, FIXED, 32'h0000_0000, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_REG_SH, asop_pkg::SH_LSR, 8'hFF, 32'hFFFF_FFFF,
                            1'b1, FIXED, 32'h0000_0000, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_REG_SH, asop_pkg::SH_ASR, 8'd32, 32'h8000_0000,
                            1'b0, FIXED, 32'hFFFF_FFFF, 1'b1));
      vectors.push_back(vec(asop_pkg::ACT_REG_SH, asop_pkg::SH_ASR, 8'hC8, 32'h7FFF_FFFF,
                            1'b1, FIXED, 32'h0000_0000, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_REG_SH, asop_pkg::SH_ROR, 8'd32, 32'h8000_0001,
                            1'b0, FIXED, 32'h8000_0001, 1'b1));
      vectors.push_back(vec(asop_pkg::ACT_REG_SH, asop_pkg::SH_ROR, 8'h40, 32'h7FFF_FFFE,
                            1'b1, FIXED, 32'h7FFF_FFFE, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_REG_SH, asop_pkg::SH_ROR, 8'd33, 32'h0000_0003,
                            1'b0, CALC, '0, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_REG_SH, asop_pkg::SH_LSL, 8'd31, 32'h0000_0003,
                            1'b0, CALC, '0, 1'b0));
      vectors.push_back(vec(asop_pkg::ACT_REG_SH, asop_pkg::SH_ASR, 8'd1, 32'h8000_0003,
                            1'b0, CALC, '0, 1'b0));
      vectors.push_back(vec(ACT_UNUSED, asop_pkg::SH_ROR, 8'hFF, 32'h1234_5678,
                            1'b1, FIXED, 32'h1234_5678, 1'b1));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (vectors[j]) begin
         issue(vectors[j].req, vectors[j].fixed, vectors[j].want, pick_gap());
      end
      drain();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) drain();
         gap = ((i / 64) % 3 == 1) ? 0 : pick_gap();
         issue(rand_request(), CALC, '0, gap);
      end

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d rotated-immediate, %0d immediate-shift, %0d register-shift, %0d unused",
               act_seen[asop_pkg::ACT_ROT_IMM], act_seen[asop_pkg::ACT_IMM_SH],
               act_seen[asop_pkg::ACT_REG_SH], act_seen[ACT_UNUSED]);
      $display("%0d responses checked (%0d hand-typed), %0d mismatches, %0d outstanding",
               n_checked, n_fixed, mismatches, due_q.size());
      if (mismatches == 0 && due_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
